// ===== rtl/bbq_pkg.sv =====
// ============================================================================
// bbq_pkg
// Shared types, constants and corner tables of the billboard quad generator.
// ============================================================================
`default_nettype none

package bbq_pkg;

    localparam int IN_BITS     = 256;
    localparam int OUT_BITS    = 96;
    localparam int USER_BITS   = 3;
    localparam int FIFO_DEPTH  = 2;
    localparam int PTR_BITS    = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS    = $clog2(FIFO_DEPTH + 1);
    localparam int CORNERS     = 6;

    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    // six products per billboard: mxx*w, mxy*h, myx*w, myy*h, mzx*w, mzy*h
    typedef struct packed {
        logic [5:0][63:0]   prod;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic               bad;
    } entry_t;

    // corner order LL, UL, LR, LR, UL, UR
    function automatic logic corner_xneg(input logic [2:0] k);
        case (k)
            3'd0, 3'd1, 3'd4: corner_xneg = 1'b1;
            default:          corner_xneg = 1'b0;
        endcase
    endfunction

    function automatic logic corner_yneg(input logic [2:0] k);
        case (k)
            3'd0, 3'd2, 3'd3: corner_yneg = 1'b1;
            default:          corner_yneg = 1'b0;
        endcase
    endfunction

    function automatic logic corner_u(input logic [2:0] k);
        case (k)
            3'd2, 3'd3, 3'd5: corner_u = 1'b1;
            default:          corner_u = 1'b0;
        endcase
    endfunction

    function automatic logic corner_v(input logic [2:0] k);
        case (k)
            3'd0, 3'd2, 3'd3: corner_v = 1'b1;
            default:          corner_v = 1'b0;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bbq_div.sv =====
// ============================================================================
// bbq_div
// Restoring divider, one quotient bit per cycle, 33-bit quotient.
// Caller guarantees num[63:33] < den.
// ============================================================================
`default_nettype none

module bbq_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [32:0] quo
);
    import bbq_pkg::*;

    logic [31:0] rem_reg;
    logic [32:0] nsh_reg;
    logic [32:0] q_reg;
    logic [31:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [32:0] trial;
    logic        ge;

    assign trial = {rem_reg, nsh_reg[32]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd33;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num[63:33]};
            nsh_reg <= num[32:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
            nsh_reg <= {nsh_reg[31:0], 1'b0};
            q_reg   <= {q_reg[31:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

`default_nettype wire

// ===== rtl/bbq_front.sv =====
// ============================================================================
// bbq_front
// Input buffer and matrix sequencer: normalizes the normal, builds the
// rotation matrix and the six width/height products of one billboard.
// ============================================================================
`default_nettype none

module bbq_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [bbq_pkg::IN_BITS-1:0] in_data,
    output logic                  push,
    output bbq_pkg::entry_t       push_entry,
    input  logic                  full
);
    import bbq_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_NORM, ST_SQX, ST_SQY, ST_SQZ, ST_PXY, ST_SQRT,
        ST_DUX, ST_DUY, ST_DUZ, ST_HALVE, ST_DXX, ST_DYY, ST_DXY,
        ST_MXX, ST_MYY, ST_MXY, ST_MFIN, ST_PROD, ST_PUSH
    } state_t;

    state_t state_reg, state_next;

    // input buffer
    logic                buf_valid_reg;
    logic [IN_BITS-1:0]  buf_reg;
    logic signed [31:0]  b_cx, b_cy, b_cz, b_nx, b_ny, b_nz;
    logic [30:0]         b_w, b_h;
    logic                take;

    // datapath
    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic [30:0]        w_reg, h_reg;
    logic [31:0]        ax_reg, ay_reg, az_reg, big_reg;
    logic               sgx_reg, sgy_reg, sgz_reg, bad_reg;
    logic [63:0]        qx_reg, qy_reg, pxy_reg;
    logic [63:0]        sq_val_reg;
    logic [33:0]        sq_rem_reg;
    logic [31:0]        sq_root_reg;
    logic [4:0]         sq_cnt_reg;
    logic [31:0]        len_reg, s2_reg, p_reg;
    logic signed [31:0] ux_reg, uy_reg, c_reg;
    logic [30:0]        rxx_reg, ryy_reg, rxy_reg;
    logic signed [31:0] mxx_reg, mxy_reg, myy_reg, mzx_reg, mzy_reg;
    logic [2:0]         pc_reg;
    logic [5:0][63:0]   pr_reg;
    logic signed [65:0] mul_reg;

    // divider handshake
    logic        div_start_reg;
    logic [63:0] div_num_reg;
    logic [31:0] div_den_reg;
    logic        div_done;
    logic [32:0] div_quo;

    // combinational helpers
    logic signed [32:0] mul_a, mul_b;
    logic [35:0]        sq_t, sq_trial;
    logic               sq_ge;
    logic [33:0]        sq_rem_n;
    logic [31:0]        sq_root_n;
    logic [63:0]        qsum;
    logic               halve;
    logic [30:0]        uzm;
    logic [33:0]        rnd30;
    logic [31:0]        mxy_mag;
    logic [31:0]        mgx, mgy, mgz, mxy_big;
    logic               n_zero, n_axis;

    assign b_cx = buf_reg[31:0];
    assign b_cy = buf_reg[63:32];
    assign b_cz = buf_reg[95:64];
    assign b_w  = buf_reg[126:96];
    assign b_h  = buf_reg[157:127];
    assign b_nx = buf_reg[189:158];
    assign b_ny = buf_reg[221:190];
    assign b_nz = buf_reg[253:222];

    assign take     = (state_reg == ST_IDLE) && buf_valid_reg;
    assign in_ready = !buf_valid_reg;

    assign mgx     = b_nx[31] ? 32'(-b_nx) : b_nx;
    assign mgy     = b_ny[31] ? 32'(-b_ny) : b_ny;
    assign mgz     = b_nz[31] ? 32'(-b_nz) : b_nz;
    assign mxy_big = (mgy > mgx) ? mgy : mgx;
    assign n_axis  = (b_nx == 32'sd0) && (b_ny == 32'sd0);
    assign n_zero  = n_axis && (b_nz == 32'sd0);

    // integer square root, two radicand bits a step
    assign sq_t      = {sq_rem_reg, sq_val_reg[63:62]};
    assign sq_trial  = {2'b00, sq_root_reg, 2'b01};
    assign sq_ge     = sq_t >= sq_trial;
    assign sq_rem_n  = sq_ge ? 34'(sq_t - sq_trial) : sq_t[33:0];
    assign sq_root_n = {sq_root_reg[30:0], sq_ge};

    assign qsum  = qx_reg + qy_reg;
    assign halve = qsum[63:32] != 32'd0;

    assign uzm     = (div_quo > 33'h0_4000_0000) ? 31'h4000_0000 : div_quo[30:0];
    assign rnd30   = 34'((mul_reg[63:0] + 64'h2000_0000) >> 30);
    assign mxy_mag = rnd30[31:0];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQX: begin mul_a = {1'b0, ax_reg}; mul_b = {1'b0, ax_reg}; end
            ST_SQY: begin mul_a = {1'b0, ay_reg}; mul_b = {1'b0, ay_reg}; end
            ST_SQZ: begin mul_a = {1'b0, az_reg}; mul_b = {1'b0, az_reg}; end
            ST_PXY: begin mul_a = {1'b0, ax_reg}; mul_b = {1'b0, ay_reg}; end
            ST_MXX: begin mul_a = {2'b00, rxx_reg}; mul_b = {1'b0, p_reg}; end
            ST_MYY: begin mul_a = {2'b00, ryy_reg}; mul_b = {1'b0, p_reg}; end
            ST_MXY: begin mul_a = {2'b00, rxy_reg}; mul_b = {1'b0, p_reg}; end
            ST_PROD:
            begin
                case (pc_reg)
                    3'd0:    begin mul_a = {mxx_reg[31], mxx_reg}; mul_b = {2'b00, w_reg}; end
                    3'd1:    begin mul_a = {mxy_reg[31], mxy_reg}; mul_b = {2'b00, h_reg}; end
                    3'd2:    begin mul_a = {mxy_reg[31], mxy_reg}; mul_b = {2'b00, w_reg}; end
                    3'd3:    begin mul_a = {myy_reg[31], myy_reg}; mul_b = {2'b00, h_reg}; end
                    3'd4:    begin mul_a = {mzx_reg[31], mzx_reg}; mul_b = {2'b00, w_reg}; end
                    3'd5:    begin mul_a = {mzy_reg[31], mzy_reg}; mul_b = {2'b00, h_reg}; end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (buf_valid_reg)
                    state_next = n_axis ? ST_PROD : ST_NORM;
            ST_NORM:  if (big_reg[31:30] != 2'b00) state_next = ST_SQX;
            ST_SQX:   state_next = ST_SQY;
            ST_SQY:   state_next = ST_SQZ;
            ST_SQZ:   state_next = ST_PXY;
            ST_PXY:   state_next = ST_SQRT;
            ST_SQRT:  if (sq_cnt_reg == 5'd31) state_next = ST_DUX;
            ST_DUX:   if (div_done) state_next = ST_DUY;
            ST_DUY:   if (div_done) state_next = ST_DUZ;
            ST_DUZ:   if (div_done) state_next = ST_HALVE;
            ST_HALVE: if (!halve) state_next = ST_DXX;
            ST_DXX:   if (div_done) state_next = ST_DYY;
            ST_DYY:   if (div_done) state_next = ST_DXY;
            ST_DXY:   if (div_done) state_next = ST_MXX;
            ST_MXX:   state_next = ST_MYY;
            ST_MYY:   state_next = ST_MXY;
            ST_MXY:   state_next = ST_MFIN;
            ST_MFIN:  state_next = ST_PROD;
            ST_PROD:  if (pc_reg == 3'd6) state_next = ST_PUSH;
            ST_PUSH:  if (!full) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            buf_valid_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_valid && in_ready)
                buf_valid_reg <= 1'b1;
            else if (take)
                buf_valid_reg <= 1'b0;
            div_start_reg <= ((state_reg == ST_SQRT) && (sq_cnt_reg == 5'd31))
                          || ((state_reg == ST_DUX) && div_done)
                          || ((state_reg == ST_DUY) && div_done)
                          || ((state_reg == ST_HALVE) && !halve)
                          || ((state_reg == ST_DXX) && div_done)
                          || ((state_reg == ST_DYY) && div_done);
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
        if (in_valid && in_ready)
            buf_reg <= in_data;
        case (state_reg)
            ST_IDLE:
            begin
                pc_reg  <= 3'd0;
                cx_reg  <= b_cx;
                cy_reg  <= b_cy;
                cz_reg  <= b_cz;
                w_reg   <= b_w;
                h_reg   <= b_h;
                ax_reg  <= mgx;
                ay_reg  <= mgy;
                az_reg  <= mgz;
                sgx_reg <= b_nx[31];
                sgy_reg <= b_ny[31];
                sgz_reg <= b_nz[31];
                big_reg <= (mgz > mxy_big) ? mgz : mxy_big;
                bad_reg <= n_zero;
                mxx_reg <= (n_axis && !n_zero && !b_nz[31]) ? -ONE_Q30 : ONE_Q30;
                mxy_reg <= '0;
                myy_reg <= ONE_Q30;
                mzx_reg <= '0;
                mzy_reg <= '0;
            end
            ST_NORM:
                if (big_reg[31:30] == 2'b00)
                begin
                    ax_reg  <= {ax_reg[30:0], 1'b0};
                    ay_reg  <= {ay_reg[30:0], 1'b0};
                    az_reg  <= {az_reg[30:0], 1'b0};
                    big_reg <= {big_reg[30:0], 1'b0};
                end
            ST_SQY: qx_reg <= mul_reg[63:0];
            ST_SQZ: qy_reg <= mul_reg[63:0];
            ST_PXY:
            begin
                sq_val_reg  <= qx_reg + qy_reg + mul_reg[63:0];
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
                sq_cnt_reg  <= '0;
            end
            ST_SQRT:
            begin
                if (sq_cnt_reg == 5'd0)
                    pxy_reg <= mul_reg[63:0];
                sq_rem_reg  <= sq_rem_n;
                sq_root_reg <= sq_root_n;
                sq_val_reg  <= {sq_val_reg[61:0], 2'b00};
                sq_cnt_reg  <= sq_cnt_reg + 5'd1;
                len_reg     <= sq_root_n;
                div_num_reg <= {2'b00, ax_reg, 30'd0} + {33'd0, sq_root_n[31:1]};
                div_den_reg <= sq_root_n;
            end
            ST_DUX:
                if (div_done)
                begin
                    ux_reg      <= sgx_reg ? -$signed(div_quo[31:0]) : $signed(div_quo[31:0]);
                    div_num_reg <= {2'b00, ay_reg, 30'd0} + {33'd0, len_reg[31:1]};
                end
            ST_DUY:
                if (div_done)
                begin
                    uy_reg      <= sgy_reg ? -$signed(div_quo[31:0]) : $signed(div_quo[31:0]);
                    div_num_reg <= {2'b00, az_reg, 30'd0} + {33'd0, len_reg[31:1]};
                end
            ST_DUZ:
                if (div_done)
                begin
                    // c = -uz, p = 1 + uz
                    c_reg <= sgz_reg ? $signed({1'b0, uzm}) : -$signed({1'b0, uzm});
                    p_reg <= sgz_reg ? 32'(32'h4000_0000 - {1'b0, uzm})
                                     : 32'(32'h4000_0000 + {1'b0, uzm});
                end
            ST_HALVE:
            begin
                if (halve)
                begin
                    qx_reg  <= {1'b0, qx_reg[63:1]};
                    qy_reg  <= {1'b0, qy_reg[63:1]};
                    pxy_reg <= {1'b0, pxy_reg[63:1]};
                end
                s2_reg      <= qsum[31:0];
                div_num_reg <= {2'b00, qy_reg[31:0], 30'd0} + {33'd0, qsum[31:1]};
                div_den_reg <= qsum[31:0];
            end
            ST_DXX:
                if (div_done)
                begin
                    rxx_reg     <= div_quo[30:0];
                    div_num_reg <= {2'b00, qx_reg[31:0], 30'd0} + {33'd0, s2_reg[31:1]};
                end
            ST_DYY:
                if (div_done)
                begin
                    ryy_reg     <= div_quo[30:0];
                    div_num_reg <= {2'b00, pxy_reg[31:0], 30'd0} + {33'd0, s2_reg[31:1]};
                end
            ST_DXY: if (div_done) rxy_reg <= div_quo[30:0];
            ST_MYY: mxx_reg <= 32'({{2{c_reg[31]}}, c_reg} + rnd30);
            ST_MXY: myy_reg <= 32'({{2{c_reg[31]}}, c_reg} + rnd30);
            ST_MFIN:
            begin
                mxy_reg <= (sgx_reg ^ sgy_reg) ? $signed(mxy_mag) : -$signed(mxy_mag);
                mzx_reg <= ux_reg;
                mzy_reg <= uy_reg;
                pc_reg  <= 3'd0;
            end
            ST_PROD:
            begin
                pc_reg <= pc_reg + 3'd1;
                if (pc_reg != 3'd0)
                    pr_reg[pc_reg - 3'd1] <= mul_reg[63:0];
            end
            default: ;
        endcase
    end

    bbq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_num_reg),
        .den   (div_den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign push            = (state_reg == ST_PUSH) && !full;
    assign push_entry.prod = pr_reg;
    assign push_entry.cx   = cx_reg;
    assign push_entry.cy   = cy_reg;
    assign push_entry.cz   = cz_reg;
    assign push_entry.bad  = bad_reg;

endmodule

`default_nettype wire

// ===== rtl/bbq_fifo.sv =====
// ============================================================================
// bbq_fifo
// Short queue of finished billboard entries between sequencer and emitter.
// ============================================================================
`default_nettype none

module bbq_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bbq_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            avail,
    output bbq_pkg::entry_t head
);
    import bbq_pkg::*;

    entry_t              slot_reg [FIFO_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] cnt_reg;

    assign full  = cnt_reg == CNT_BITS'(FIFO_DEPTH);
    assign avail = cnt_reg != '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + CNT_BITS'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !avail))
        else $error("queue read while empty");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_BITS'(FIFO_DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/bbq_back.sv =====
// ============================================================================
// bbq_back
// Corner emitter: one vertex per cycle unless stalled, sign-combine, round, translate,
// saturate, three register stages with a common stall.
// ============================================================================
`default_nettype none

module bbq_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            avail,
    input  bbq_pkg::entry_t head,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [bbq_pkg::OUT_BITS-1:0]  out_data,
    output logic [bbq_pkg::USER_BITS-1:0] out_user,
    output logic            out_last
);
    import bbq_pkg::*;

    typedef struct packed {
        logic               u;
        logic               v;
        logic               last;
        logic               bad;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
    } meta_t;

    entry_t     cur_reg;
    logic       active_reg;
    logic [2:0] k_reg;
    logic       adv;
    logic       issue;

    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg;
    meta_t              s1_meta_reg, s2_meta_reg;
    logic signed [64:0] s1_sum_reg [3];
    logic signed [33:0] s2_rnd_reg [3];
    logic [31:0]        s3_c_reg [3];
    logic [2:0]         s3_user_reg;
    logic               s3_last_reg;

    logic xn, yn;

    function automatic logic signed [64:0] term(input logic [63:0] p, input logic neg);
        logic signed [64:0] e;
        e    = {p[63], p};
        term = neg ? -e : e;
    endfunction

    function automatic logic signed [33:0] rnd31(input logic signed [64:0] s);
        logic signed [64:0] t;
        t     = s + (s[64] ? 65'sh3FFF_FFFF : 65'sh4000_0000);
        rnd31 = t[64:31];
    endfunction

    function automatic logic [31:0] sat(input logic signed [33:0] r,
                                        input logic signed [31:0] c);
        logic signed [34:0] t;
        t = {r[33], r} + {{3{c[31]}}, c};
        if (t > 35'sh0_7FFF_FFFF)
            sat = 32'h7FFF_FFFF;
        else if (t < -35'sh0_8000_0000)
            sat = 32'h8000_0000;
        else
            sat = t[31:0];
    endfunction

    assign adv   = !s3_valid_reg || out_ready;
    assign issue = adv && active_reg;
    assign pop   = avail && (!active_reg || (issue && (k_reg == 3'd5)));
    assign xn    = corner_xneg(k_reg);
    assign yn    = corner_yneg(k_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            k_reg        <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                active_reg <= 1'b1;
                k_reg      <= 3'd0;
            end
            else if (issue)
            begin
                if (k_reg == 3'd5)
                    active_reg <= 1'b0;
                k_reg <= k_reg + 3'd1;
            end
            if (adv)
            begin
                s1_valid_reg <= issue;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head;
        if (adv)
        begin
            s1_sum_reg[0] <= term(cur_reg.prod[0], xn) + term(cur_reg.prod[1], yn);
            s1_sum_reg[1] <= term(cur_reg.prod[2], xn) + term(cur_reg.prod[3], yn);
            s1_sum_reg[2] <= term(cur_reg.prod[4], xn) + term(cur_reg.prod[5], yn);
            s1_meta_reg   <= '{u: corner_u(k_reg), v: corner_v(k_reg),
                               last: (k_reg == 3'd5), bad: cur_reg.bad,
                               cx: cur_reg.cx, cy: cur_reg.cy, cz: cur_reg.cz};
            for (int i = 0; i < 3; i++)
                s2_rnd_reg[i] <= rnd31(s1_sum_reg[i]);
            s2_meta_reg <= s1_meta_reg;
            s3_c_reg[0] <= sat(s2_rnd_reg[0], s2_meta_reg.cx);
            s3_c_reg[1] <= sat(s2_rnd_reg[1], s2_meta_reg.cy);
            s3_c_reg[2] <= sat(s2_rnd_reg[2], s2_meta_reg.cz);
            s3_user_reg <= {s2_meta_reg.bad, s2_meta_reg.v, s2_meta_reg.u};
            s3_last_reg <= s2_meta_reg.last;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_data  = {s3_c_reg[2], s3_c_reg[1], s3_c_reg[0]};
    assign out_user  = s3_user_reg;
    assign out_last  = s3_last_reg;

    a_corner_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (k_reg <= 3'd5))
        else $error("corner index out of range");
    a_pop_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && active_reg) |-> (k_reg == 3'd5))
        else $error("new billboard loaded mid-quad");

endmodule

`default_nettype wire

// ===== rtl/billboard_quad_vertex_generator_unit.sv =====
// ============================================================================
// billboard_quad_vertex_generator_unit
// Expands one billboard into six textured vertices (two triangles).
// ============================================================================
`default_nettype none

// Each accepted input word describes a billboard (center, width, height and a
// facing normal of any length, all Q15.16); the block returns six vertex
// words in the order LL, UL, LR, LR, UL, UR, with tlast on the sixth. Corners
// at +-w/2, +-h/2 in the xy plane are rotated so that (0,0,-1) turns onto the
// normal, translated by the center and saturated to signed Q15.16. A zero
// normal gives no rotation and sets bad_normal on all six vertices; a normal
// along -z gives no rotation, one along +z a half turn (x and z negated).
// The matrix sequencer's run for a general normal is set by the shared
// one-bit-per-cycle divider (six divides), the 32-step square root, the
// normalizing shift and the halving shift; a zero or axis normal skips
// all of them. The vertex emitter streams one vertex per cycle while the
// output does not stall; an entry taken from the queue is held in a
// register and each vertex passes the sum, round and saturate registers. A
// two-entry queue between the two lets the sequencer start the next
// billboard while earlier vertices are still draining, and a one-word input
// buffer takes the next billboard while the sequencer is busy.
module billboard_quad_vertex_generator_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // center_x, center_y, center_z, width, height, normal_x, normal_y,
    // normal_z (lowest first), 2 zero pad bits at the top
    input  logic [255:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // corner_x, corner_y, corner_z (lowest first)
    output logic [95:0]  m_axis_tdata,
    // tex_u, tex_v, bad_normal (lowest first)
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast
);
    import bbq_pkg::*;

    entry_t push_entry, head;
    logic   push, full, pop, avail;

    bbq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .push       (push),
        .push_entry (push_entry),
        .full       (full)
    );

    bbq_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .avail      (avail),
        .head       (head)
    );

    bbq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .avail     (avail),
        .head      (head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the billboard quad vertex generator.
// Billboards go in on the slave stream. A scoreboard works out the six
// expected vertex words of each billboard in fixed point and compares every
// word that leaves the master stream, field by field. Both sides idle and
// stall at random.
// ============================================================================
`default_nettype none

module tb_top;

    import bbq_pkg::*;

    localparam int  N_RANDOM  = 400;
    localparam int  MAX_CYC   = 1000000;
    localparam int  DRAIN_CYC = 400;
    localparam longint ONE30  = 64'sd1 << 30;

    // corner order LL, UL, LR, LR, UL, UR
    localparam int SIGN_X[6] = '{-1, -1, 1, 1, -1, 1};
    localparam int SIGN_Y[6] = '{-1, 1, -1, -1, 1, 1};
    localparam bit TEX_U[6]  = '{0, 0, 1, 1, 0, 1};
    localparam bit TEX_V[6]  = '{1, 0, 1, 1, 0, 0};

    typedef struct {
        logic signed [31:0] cx, cy, cz;
        logic [30:0]        w, h;
        logic signed [31:0] nx, ny, nz;
    } billboard_t;

    typedef struct {
        logic signed [31:0] x, y, z;
        bit                 u, v, last, bad;
    } vertex_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;

    int cycles = 0;

    billboard_t directed[$];

    // ------------------------------------------------------------------------
    // scoreboard: predicts the six vertices of each billboard
    // ------------------------------------------------------------------------
    class vertex_scoreboard;
        vertex_t pending[$];
        int      errors;

        task report(input string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function longint unsigned mag(longint v);
            return (v < 0) ? longint'(-v) : v;
        endfunction

        // shift right by s, rounding half away from zero
        function longint rshift_round(longint v, int s);
            longint unsigned m;
            m = (mag(v) + (64'd1 << (s - 1))) >> s;
            return (v < 0) ? -longint'(m) : longint'(m);
        endfunction

        function longint div_round(longint num, longint unsigned den);
            longint unsigned m;
            m = (mag(num) + den / 2) / den;
            return (num < 0) ? -longint'(m) : longint'(m);
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function void note_billboard(billboard_t b);
            longint nx, ny, nz, mxx, mxy, myx, myy, mzx, mzy;
            longint scale, ux, uy, uz, c, p, rxx, ryy, rxy, px, py;
            longint unsigned big, qx, qy, pxy, s2, len;
            bit      bad;
            vertex_t vt;
            nx = b.nx; ny = b.ny; nz = b.nz;
            mxx = ONE30; myy = ONE30; mxy = 0; myx = 0; mzx = 0; mzy = 0;
            bad = 0;
            if (nx == 0 && ny == 0 && nz == 0) begin
                bad = 1;
            end else if (nx == 0 && ny == 0) begin
                // facing +z: half turn about y
                if (nz > 0) mxx = -ONE30;
            end else begin
                big = mag(nx);
                if (mag(ny) > big) big = mag(ny);
                if (mag(nz) > big) big = mag(nz);
                scale = 1;
                while (big < (64'd1 << 30)) begin
                    big <<= 1;
                    scale <<= 1;
                end
                nx *= scale; ny *= scale; nz *= scale;
                qx  = mag(nx) * mag(nx);
                qy  = mag(ny) * mag(ny);
                len = int_sqrt(qx + qy + mag(nz) * mag(nz));
                ux  = div_round(nx * ONE30, len);
                uy  = div_round(ny * ONE30, len);
                uz  = div_round(nz * ONE30, len);
                if (uz > ONE30) uz = ONE30;
                if (uz < -ONE30) uz = -ONE30;
                c   = -uz;
                p   = ONE30 + uz;
                pxy = mag(nx) * mag(ny);
                while (qx + qy >= (64'd1 << 32)) begin
                    qx >>= 1; qy >>= 1; pxy >>= 1;
                end
                s2  = qx + qy;
                rxx = ((qy << 30) + s2 / 2) / s2;
                ryy = ((qx << 30) + s2 / 2) / s2;
                rxy = ((pxy << 30) + s2 / 2) / s2;
                if ((nx < 0) != (ny < 0)) rxy = -rxy;
                mxx = c + rshift_round(rxx * p, 30);
                myy = c + rshift_round(ryy * p, 30);
                mxy = -rshift_round(rxy * p, 30);
                myx = mxy;
                mzx = ux;
                mzy = uy;
            end
            for (int k = 0; k < 6; k++) begin
                px = SIGN_X[k] * longint'(b.w);
                py = SIGN_Y[k] * longint'(b.h);
                vt.x = sat32(rshift_round(mxx * px + mxy * py, 31) + b.cx);
                vt.y = sat32(rshift_round(myx * px + myy * py, 31) + b.cy);
                vt.z = sat32(rshift_round(mzx * px + mzy * py, 31) + b.cz);
                vt.u = TEX_U[k];
                vt.v = TEX_V[k];
                vt.last = (k == 5);
                vt.bad = bad;
                pending = {pending, vt};
            end
        endfunction

        task check_vertex(vertex_t got);
            vertex_t e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected vertex x=%0d", got.x));
                return;
            end
            e = pending.pop_front();
            if (got.x !== e.x) report($sformatf("x %0d exp %0d", got.x, e.x));
            if (got.y !== e.y) report($sformatf("y %0d exp %0d", got.y, e.y));
            if (got.z !== e.z) report($sformatf("z %0d exp %0d", got.z, e.z));
            if (got.u !== e.u) report($sformatf("tex_u %0b exp %0b", got.u, e.u));
            if (got.v !== e.v) report($sformatf("tex_v %0b exp %0b", got.v, e.v));
            if (got.last !== e.last)
                report($sformatf("tlast %0b exp %0b", got.last, e.last));
            if (got.bad !== e.bad)
                report($sformatf("bad_normal %0b exp %0b", got.bad, e.bad));
        endtask
    endclass

    vertex_scoreboard sb;

    billboard_quad_vertex_generator_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(60, 15);
    endfunction

    // ------------------------------------------------------------------------
    // run watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYC)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // output side: random back-pressure, with calm stretches
    // ------------------------------------------------------------------------
    int  stall_left;
    bit  calm;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
            calm          <= 1'b0;
        end
        else
        begin
            if ($urandom_range(299) == 0) calm <= ~calm;
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left    <= stall_left - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(4) == 0) stall_left <= gap_len();
            end
        end
    end

    // outputs settle between edges; a word moves at the next rising edge
    always @(negedge clk)
    begin
        vertex_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.x    = m_axis_tdata[31:0];
            got.y    = m_axis_tdata[63:32];
            got.z    = m_axis_tdata[95:64];
            got.u    = m_axis_tuser[0];
            got.v    = m_axis_tuser[1];
            got.bad  = m_axis_tuser[2];
            got.last = m_axis_tlast;
            sb.check_vertex(got);
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    task send_billboard(billboard_t b, bit no_gap);
        bit rdy;
        int g;
        s_axis_tdata  <= {2'b00, b.nz, b.ny, b.nx, b.h, b.w, b.cz, b.cy, b.cx};
        s_axis_tvalid <= 1'b1;
        do
        begin
            @(negedge clk);
            rdy = s_axis_tready;
            @(posedge clk);
        end while (!rdy);
        sb.note_billboard(b);
        g = no_gap ? 0 : gap_len();
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    function automatic billboard_t make_bb(int cx, int cy, int cz, int w, int h,
                                           int nx, int ny, int nz);
        billboard_t b;
        b.cx = cx; b.cy = cy; b.cz = cz;
        b.w = w[30:0]; b.h = h[30:0];
        b.nx = nx; b.ny = ny; b.nz = nz;
        return b;
    endfunction

    function automatic void queue_directed(billboard_t b);
        directed = {directed, b};
    endfunction

    function automatic billboard_t random_bb();
        billboard_t b;
        int sel;
        b.cx = $urandom; b.cy = $urandom; b.cz = $urandom;
        b.w = $urandom; b.h = $urandom;
        b.nx = $urandom; b.ny = $urandom; b.nz = $urandom;
        sel = $urandom_range(9);
        // half of the billboards are of sane size near the origin
        if (sel < 5)
        begin
            b.cx = $signed(b.cx) >>> $urandom_range(20, 4);
            b.cy = $signed(b.cy) >>> $urandom_range(20, 4);
            b.cz = $signed(b.cz) >>> $urandom_range(20, 4);
            b.w  = b.w >> $urandom_range(20, 4);
            b.h  = b.h >> $urandom_range(20, 4);
        end
        // short normals exercise the normalizing shift
        if (sel == 1 || sel == 2)
        begin
            b.nx = $signed(b.nx) >>> $urandom_range(31, 10);
            b.ny = $signed(b.ny) >>> $urandom_range(31, 10);
            b.nz = $signed(b.nz) >>> $urandom_range(31, 10);
        end
        // degenerate, axis-aligned and partly zero normals
        if (sel == 6)
        begin
            case ($urandom_range(4))
                0: begin b.nx = 0; b.ny = 0; b.nz = 0; end
                1: begin b.nx = 0; b.ny = 0; end
                2: b.nz = 0;
                3: b.nx = 0;
                default: b.ny = 0;
            endcase
        end
        return b;
    endfunction

    initial
    begin
        sb = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero normal, normals along -z, +z and +x, with size extremes
        queue_directed(make_bb(0, 0, 0, 32'h0002_0000, 32'h0004_0000, 0, 0, 0));
        queue_directed(make_bb(32'h7fff_ffff, 32'h8000_0000, 5, 32'h7fff_ffff,
                               32'h7fff_ffff, 0, 0, 0));
        queue_directed(make_bb(100, -100, 7, 32'h0003_0000, 32'h0001_0000,
                               0, 0, -1));
        queue_directed(make_bb(0, 0, 0, 32'h0003_0000, 32'h0001_0000,
                               0, 0, 32'h8000_0000));
        queue_directed(make_bb(-5, 9, 3, 32'h0003_0000, 32'h0001_0000, 0, 0, 1));
        queue_directed(make_bb(32'h7fff_0000, 32'h7fff_0000, 32'h7fff_0000,
                               32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 32'h7fff_ffff));
        queue_directed(make_bb(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               32'h7fff_ffff, 32'h7fff_ffff, 1, 0, 0));
        // general normals, including all-extreme components
        queue_directed(make_bb(0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff,
                               32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        queue_directed(make_bb(1, 2, 3, 32'h0001_0000, 32'h0001_0000,
                               32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        queue_directed(make_bb(0, 0, 0, 32'h0002_0000, 32'h0002_0000, 0, 1, 0));
        queue_directed(make_bb(0, 0, 0, 32'h0002_0000, 32'h0002_0000, -1, 0, 0));
        queue_directed(make_bb(0, 0, 0, 32'h0002_0000, 32'h0004_0000,
                               32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        queue_directed(make_bb(-7, 7, 0, 32'h0002_0000, 32'h0004_0000,
                               -3, 4, -5));
        queue_directed(make_bb(0, 0, 0, 0, 0, 2, -3, 1));
        queue_directed(make_bb(32'h8000_0000, 32'h7fff_ffff, 0, 32'h7fff_ffff, 0,
                               32'h8000_0000, 32'h7fff_ffff, 0));
        queue_directed(make_bb(0, 0, 0, 1, 1, 1, 1, -32'h7fff_ffff));
        queue_directed(make_bb(0, 0, 0, 32'h0001_0000, 32'h0001_0000,
                               32'hffff_ffff, 0, 32'h7fff_ffff));
        foreach (directed[i]) send_billboard(directed[i], i < 4);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            // once, let the output side run dry before going on
            if (i == N_RANDOM / 2)
            begin
                s_axis_tvalid <= 1'b0;
                while (sb.pending.size() != 0) @(posedge clk);
            end
            send_billboard(random_bb(), 1'b0);
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== billboard_quad_vertex_generator_unit.f =====
rtl/bbq_pkg.sv
rtl/bbq_div.sv
rtl/bbq_front.sv
rtl/bbq_fifo.sv
rtl/bbq_back.sv
rtl/billboard_quad_vertex_generator_unit.sv
verif/tb_top.sv
